@@ src/spc_pkg.sv @@
// package for the strict priority call scheduler
// holds the request and result payload types, class and operation codes and the control states
// no dependencies
package spc_pkg;

  localparam int NUM_CLASSES         = 4;
  localparam int CLASS_W             = 2;
  localparam int ID_W                = 16;
  localparam int STIME_W             = 16;
  localparam int TICK_W              = 32;
  localparam int ENTRY_W             = ID_W + STIME_W;
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_PLATINUM = 2'd0,
    CLASS_GOLD     = 2'd1,
    CLASS_SILVER   = 2'd2,
    CLASS_REGULAR  = 2'd3
  } class_t;

  typedef struct packed {
    logic               operation;
    logic [CLASS_W-1:0] service_class;
    logic [ID_W-1:0]    requester_id;
    logic [STIME_W-1:0] service_time;
  } req_t;

  typedef struct packed {
    logic               answered;
    logic [ID_W-1:0]    served_id;
    logic [CLASS_W-1:0] served_class;
    logic               dropped;
    logic               server_busy;
    logic [TICK_W-1:0]  tick_number;
  } rsp_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

@@ src/spc_req_if.sv @@
// request channel of the scheduler: valid, ready and one request payload
// depends on spc_pkg
interface spc_req_if;
  logic          valid;
  logic          ready;
  spc_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/spc_rsp_if.sv @@
// result channel of the scheduler: valid, ready and one result payload
// depends on spc_pkg
interface spc_rsp_if;
  logic          valid;
  logic          ready;
  spc_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/spc_ram.sv @@
// generic single port ram with registered read data
// no dependencies
module spc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/strict_priority_call_scheduler_unit.sv @@
// top level of the strict priority call scheduler: four class queues in one shared ram
// feeding one server; depends on spc_pkg, spc_req_if, spc_rsp_if and spc_ram
// arrivals and ticks that start no service register their result when the request is taken;
// a tick that starts a service first reads the queue ram in ST_READ, then registers its result
// throughput: one request per cycle while the result buffer has room, except a serving tick,
// which holds the input in ST_READ; results wait in a two entry buffer; reset is synchronous
// and clears pointers, busy counter, tick counter and buffer; the queue ram is not cleared
module strict_priority_call_scheduler_unit #(
  parameter int QUEUE_DEPTH = spc_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  spc_req_if.sink    req,
  spc_rsp_if.source  rsp
);

  localparam int PTR_MOD = 2 * QUEUE_DEPTH;
  localparam int PTR_W   = $clog2(PTR_MOD);
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int DEPTH   = spc_pkg::NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(PTR_MOD - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [spc_pkg::CLASS_W-1:0] c,
                                                input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0]  s;
    logic [SLOT_W-1:0] slot;
    if (p >= PTR_W'(QUEUE_DEPTH)) begin
      s = p - PTR_W'(QUEUE_DEPTH);
    end else begin
      s = p;
    end
    slot = s[SLOT_W-1:0];
    return ADDR_W'(ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(slot);
  endfunction

  spc_pkg::state_t state, state_next;

  logic [PTR_W-1:0]               head [spc_pkg::NUM_CLASSES];
  logic [PTR_W-1:0]               tail [spc_pkg::NUM_CLASSES];
  logic [spc_pkg::STIME_W-1:0]    busy;
  logic [spc_pkg::TICK_W-1:0]     tick_count;
  logic [spc_pkg::CLASS_W-1:0]    pend_class;
  logic [spc_pkg::TICK_W-1:0]     pend_tick;

  spc_pkg::rsp_t                  rsp_q [2];
  logic                           wr_ptr;
  logic                           rd_ptr;
  logic [1:0]                     count;

  logic [spc_pkg::NUM_CLASSES-1:0] nonempty;
  logic [spc_pkg::NUM_CLASSES-1:0] full;
  logic [PTR_W:0]                  fill [spc_pkg::NUM_CLASSES];
  logic                            any_nonempty;
  logic [spc_pkg::CLASS_W-1:0]     sel;

  logic                            acc;
  logic                            is_tick;
  logic                            start_read;
  logic                            push;
  logic                            pop;
  spc_pkg::rsp_t                   push_data;

  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_addr;
  logic [spc_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [spc_pkg::ENTRY_W-1:0]     ram_rdata;
  logic [spc_pkg::STIME_W-1:0]     rd_stime;
  logic [spc_pkg::ID_W-1:0]        rd_id;

  // per class fill state
  always_comb begin
    for (int c = 0; c < spc_pkg::NUM_CLASSES; c++) begin
      if (tail[c] >= head[c]) begin
        fill[c] = {1'b0, tail[c]} - {1'b0, head[c]};
      end else begin
        fill[c] = {1'b0, tail[c]} + (PTR_W+1)'(PTR_MOD) - {1'b0, head[c]};
      end
      nonempty[c] = (head[c] != tail[c]);
      full[c]     = (fill[c] >= (PTR_W+1)'(QUEUE_DEPTH));
    end
  end

  // lowest numbered nonempty class wins
  always_comb begin
    sel = spc_pkg::CLASS_REGULAR;
    for (int c = spc_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
      if (nonempty[c]) begin
        sel = spc_pkg::CLASS_W'(c);
      end
    end
    any_nonempty = |nonempty;
  end

  assign acc        = req.valid && req.ready;
  assign is_tick    = (req.payload.operation == spc_pkg::OP_TICK);
  assign start_read = acc && is_tick && (busy == '0) && any_nonempty;
  assign pop        = rsp.valid && rsp.ready;

  assign ram_we    = acc && !is_tick && !full[req.payload.service_class];
  assign ram_wdata = {req.payload.service_time, req.payload.requester_id};
  assign ram_addr  = is_tick ? addr_of(sel, head[sel])
                             : addr_of(req.payload.service_class,
                                       tail[req.payload.service_class]);
  assign rd_stime  = ram_rdata[spc_pkg::ENTRY_W-1:spc_pkg::ID_W];
  assign rd_id     = ram_rdata[spc_pkg::ID_W-1:0];

  spc_ram #(
    .WIDTH(spc_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      spc_pkg::ST_IDLE: begin
        if (start_read) begin
          state_next = spc_pkg::ST_READ;
        end
      end
      spc_pkg::ST_READ: begin
        state_next = spc_pkg::ST_IDLE;
      end
      default: begin
        state_next = spc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the control
  always_comb begin
    req.ready = 1'b0;
    push      = 1'b0;
    push_data = '0;
    case (state)
      spc_pkg::ST_IDLE: begin
        req.ready = (count != 2'd2);
        push      = acc && !start_read;
        push_data.tick_number = tick_count;
        if (is_tick) begin
          push_data.server_busy = (busy > spc_pkg::STIME_W'(1));
        end else begin
          push_data.dropped     = full[req.payload.service_class];
          push_data.server_busy = (busy != '0);
        end
      end
      spc_pkg::ST_READ: begin
        push                   = 1'b1;
        push_data.answered     = 1'b1;
        push_data.served_id    = rd_id;
        push_data.served_class = pend_class;
        push_data.server_busy  = (rd_stime > spc_pkg::STIME_W'(1));
        push_data.tick_number  = pend_tick;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spc_pkg::ST_IDLE;
      busy       <= '0;
      tick_count <= '0;
      for (int c = 0; c < spc_pkg::NUM_CLASSES; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (ram_we) begin
        tail[req.payload.service_class] <= ptr_inc(tail[req.payload.service_class]);
      end
      if (acc && is_tick) begin
        tick_count <= tick_count + spc_pkg::TICK_W'(1);
        if (start_read) begin
          head[sel] <= ptr_inc(head[sel]);
        end else if (busy != '0) begin
          busy <= busy - spc_pkg::STIME_W'(1);
        end
      end
      if (state == spc_pkg::ST_READ) begin
        busy <= (rd_stime != '0) ? rd_stime - spc_pkg::STIME_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_read) begin
      pend_class <= sel;
      pend_tick  <= tick_count;
    end
  end

  // two entry result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp_q[wr_ptr] <= push_data;
    end
  end

  assign rsp.valid   = (count != '0);
  assign rsp.payload = rsp_q[rd_ptr];

endmodule

@@ src/spc_checker.sv @@
// port level checks for the strict priority call scheduler, bound to the top level
// depends on spc_pkg and strict_priority_call_scheduler_unit
module spc_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spc_pkg::rsp_t rsp_payload
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("stalled result changed");

  // no result right after reset
  assert property (@(posedge clk) $past(rst) && !rst |-> !rsp_valid)
    else $error("result present after reset");

  // an answered result never reports a drop
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.answered |-> !rsp_payload.dropped)
    else $error("answered result flagged as dropped");

  // unserved results carry no id or class
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_payload.answered |->
      rsp_payload.served_id == '0 && rsp_payload.served_class == '0)
    else $error("unserved result carries id or class");

endmodule

bind strict_priority_call_scheduler_unit spc_checker u_spc_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_payload(rsp.payload)
);
